@@ rtl/core/elim_pkg.sv @@
// Shared types, token kind codes and character class helpers for the
// expression lexer. Used by every module of the block; depends on nothing.
package elim_pkg;

    // Token kinds as they appear on the output.
    localparam logic [3:0] KIND_NUM    = 4'd0;
    localparam logic [3:0] KIND_IDENT  = 4'd1;
    localparam logic [3:0] KIND_SQRT   = 4'd2;
    localparam logic [3:0] KIND_PLUS   = 4'd3;
    localparam logic [3:0] KIND_MINUS  = 4'd4;
    localparam logic [3:0] KIND_MUL    = 4'd5;
    localparam logic [3:0] KIND_DIV    = 4'd6;
    localparam logic [3:0] KIND_POW    = 4'd7;
    localparam logic [3:0] KIND_LPAREN = 4'd8;
    localparam logic [3:0] KIND_RPAREN = 4'd9;
    localparam logic [3:0] KIND_COMMA  = 4'd10;
    localparam logic [3:0] KIND_NONE   = 4'd15;

    // Scanner modes.
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_NUM   = 2'd1;
    localparam logic [1:0] MODE_IDENT = 2'd2;

    // Keyword prefix tracker: 0..4 characters of "sqrt" matched, or mismatch.
    localparam logic [2:0] MATCH_FULL = 3'd4;
    localparam logic [2:0] MATCH_FAIL = 3'd5;

    // Longest token length and the most tokens one character can cause.
    localparam logic [8:0] LEN_MAX = 9'd256;
    localparam int         TOK_MAX = 3;
    localparam int         QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] start;
        logic [8:0] length;
    } tok_t;

    // Everything one character produced, handed from front to back.
    typedef struct packed {
        tok_t [TOK_MAX-1:0] tok;
        logic [1:0]         count;
        logic               eol;
        logic               too_long;
    } bundle_t;

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        is_alpha = ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    endfunction

    function automatic logic starts_ident(input logic [7:0] c);
        starts_ident = is_alpha(c) || (c == "_");
    endfunction

    function automatic logic in_ident(input logic [7:0] c);
        in_ident = is_alpha(c) || is_digit(c) || (c == "_");
    endfunction

    function automatic logic in_number(input logic [7:0] c);
        in_number = is_digit(c) || (c == ".");
    endfunction

    function automatic logic is_atom(input logic [3:0] k);
        is_atom = (k == KIND_NUM) || (k == KIND_IDENT) || (k == KIND_RPAREN);
    endfunction

    // Character of "sqrt" expected after the given number of matched ones.
    function automatic logic [7:0] kw_char(input logic [2:0] idx);
        case (idx)
            3'd0:    kw_char = "s";
            3'd1:    kw_char = "q";
            3'd2:    kw_char = "r";
            3'd3:    kw_char = "t";
            default: kw_char = 8'h00;
        endcase
    endfunction

    // Single-character operator lookup; KIND_NONE for anything skipped.
    function automatic logic [3:0] op_kind(input logic [7:0] c);
        case (c)
            "+":     op_kind = KIND_PLUS;
            "-":     op_kind = KIND_MINUS;
            "*":     op_kind = KIND_MUL;
            "/":     op_kind = KIND_DIV;
            "^":     op_kind = KIND_POW;
            "(":     op_kind = KIND_LPAREN;
            ")":     op_kind = KIND_RPAREN;
            ",":     op_kind = KIND_COMMA;
            default: op_kind = KIND_NONE;
        endcase
    endfunction

endpackage

@@ rtl/core/elim_front.sv @@
// Front end of the lexer: accepts characters, keeps the scanner state and
// turns each character into a bundle of up to three tokens. Uses elim_pkg.
module elim_front #(
    parameter int MAX_LINE = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [7:0]        in_char,
    input  logic              in_eol,
    input  logic              q_full,
    output logic              in_ready,
    output logic              push,
    output elim_pkg::bundle_t push_data
);
    import elim_pkg::*;

    localparam int POS_CAP_I = (MAX_LINE < 256) ? MAX_LINE : 256;
    localparam logic [8:0] POS_CAP = 9'(POS_CAP_I);
    localparam logic [7:0] POS_LAST = 8'(POS_CAP_I - 1);

    logic [1:0] mode_reg, mode_next;
    logic [7:0] start_reg, start_next;
    logic [8:0] len_reg, len_next;
    logic [3:0] prev_reg, prev_next;
    logic [2:0] km_reg, km_next;
    logic [8:0] cpos_reg, cpos_next;
    logic       ovf_reg, ovf_next;

    logic       accept;
    logic [7:0] pos;
    logic       continues;
    logic [3:0] close_kind;
    logic [3:0] op;
    logic [1:0] n;
    bundle_t    bnd;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Scanner step for one character.
    always_comb
    begin
        mode_next  = mode_reg;
        start_next = start_reg;
        len_next   = len_reg;
        prev_next  = prev_reg;
        km_next    = km_reg;
        cpos_next  = cpos_reg;
        ovf_next   = ovf_reg;
        n          = 2'd0;
        bnd        = '0;
        close_kind = KIND_NUM;
        op         = op_kind(in_char);

        // Position saturates at the line limit and flags the overflow.
        if (cpos_reg >= POS_CAP)
        begin
            ovf_next = 1'b1;
            pos      = POS_LAST;
        end
        else
        begin
            pos       = cpos_reg[7:0];
            cpos_next = cpos_reg + 9'd1;
        end

        continues = ((mode_reg == MODE_NUM) && in_number(in_char)) ||
                    ((mode_reg == MODE_IDENT) && in_ident(in_char));

        if (continues)
        begin
            if (len_reg < LEN_MAX)
                len_next = len_reg + 9'd1;
            if (mode_reg == MODE_IDENT)
            begin
                if ((km_reg < MATCH_FULL) && (in_char == kw_char(km_reg)))
                    km_next = km_reg + 3'd1;
                else
                    km_next = MATCH_FAIL;
            end
        end
        else
        begin
            // Any other character ends the open run.
            if (mode_reg != MODE_IDLE)
            begin
                if (mode_reg == MODE_IDENT)
                    close_kind = ((km_reg == MATCH_FULL) && (len_reg == 9'd4)) ?
                                 KIND_SQRT : KIND_IDENT;
                bnd.tok[n] = '{kind: close_kind, start: start_reg, length: len_reg};
                n          = n + 2'd1;
                prev_next  = close_kind;
                mode_next  = MODE_IDLE;
            end
            if (in_number(in_char) || starts_ident(in_char))
            begin
                if (is_atom(prev_next))
                begin
                    bnd.tok[n] = '{kind: KIND_MUL, start: pos, length: 9'd0};
                    n          = n + 2'd1;
                    prev_next  = KIND_MUL;
                end
                mode_next  = in_number(in_char) ? MODE_NUM : MODE_IDENT;
                start_next = pos;
                len_next   = 9'd1;
                km_next    = (in_char == "s") ? 3'd1 : MATCH_FAIL;
            end
            else
            begin
                if ((op == KIND_LPAREN) && is_atom(prev_next))
                begin
                    bnd.tok[n] = '{kind: KIND_MUL, start: pos, length: 9'd0};
                    n          = n + 2'd1;
                    prev_next  = KIND_MUL;
                end
                if (op != KIND_NONE)
                begin
                    bnd.tok[n] = '{kind: op, start: pos, length: 9'd1};
                    n          = n + 2'd1;
                    prev_next  = op;
                end
            end
        end

        // The line end flushes whatever run is still open.
        if (in_eol && (mode_next != MODE_IDLE))
        begin
            close_kind = KIND_NUM;
            if (mode_next == MODE_IDENT)
                close_kind = ((km_next == MATCH_FULL) && (len_next == 9'd4)) ?
                             KIND_SQRT : KIND_IDENT;
            bnd.tok[n] = '{kind: close_kind, start: start_next, length: len_next};
            n          = n + 2'd1;
            prev_next  = close_kind;
            mode_next  = MODE_IDLE;
        end

        bnd.count    = n;
        bnd.eol      = in_eol;
        bnd.too_long = ovf_next;

        if (in_eol)
        begin
            mode_next  = MODE_IDLE;
            start_next = 8'd0;
            len_next   = 9'd0;
            prev_next  = KIND_NONE;
            km_next    = 3'd0;
            cpos_next  = 9'd0;
            ovf_next   = 1'b0;
        end
    end

    assign push      = accept && (n != 2'd0);
    assign push_data = bnd;

    // Scanner state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            start_reg <= 8'd0;
            len_reg   <= 9'd0;
            prev_reg  <= KIND_NONE;
            km_reg    <= 3'd0;
            cpos_reg  <= 9'd0;
            ovf_reg   <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            prev_reg  <= prev_next;
            km_reg    <= km_next;
            cpos_reg  <= cpos_next;
            ovf_reg   <= ovf_next;
        end
    end

    // The position counter never runs past the line limit.
    a_pos_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cpos_reg <= POS_CAP)
        else $error("position counter beyond line limit");

    // The overflow flag only stands once the counter has reached the limit.
    a_ovf_pos: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (cpos_reg == POS_CAP))
        else $error("overflow flag without a saturated position");

    // An open run always has at least one character.
    a_open_len: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != MODE_IDLE) |-> (len_reg != 9'd0))
        else $error("open run with zero length");

endmodule

@@ rtl/core/elim_queue.sv @@
// Two-entry queue of token bundles between the lexer front and back ends.
// Uses elim_pkg for the bundle type and the queue depth.
module elim_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  elim_pkg::bundle_t push_data,
    input  logic              pop,
    output logic              full,
    output logic              head_valid,
    output elim_pkg::bundle_t head
);
    import elim_pkg::*;

    bundle_t    mem_reg [QUEUE_DEPTH];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full       = (cnt_reg == 2'(QUEUE_DEPTH));
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = mem_reg[rd_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_next  = push ? !wr_reg : wr_reg;
        rd_next  = pop ? !rd_reg : rd_reg;
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (!push && pop)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_data;
    end

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");

    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue read while empty");

    a_nonempty_bundle: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (push_data.count != 2'd0))
        else $error("empty bundle queued");

    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd1) |-> (wr_reg != rd_reg))
        else $error("queue pointers disagree with fill count");

endmodule

@@ rtl/core/elim_back.sv @@
// Back end of the lexer: walks the head bundle one token at a time into the
// output register. Uses elim_pkg for the bundle and token types.
module elim_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  elim_pkg::bundle_t head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output elim_pkg::tok_t    out_tok,
    output logic              out_last,
    output logic              out_line_done,
    output logic              out_too_long
);
    import elim_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg;
    tok_t       tok_reg;
    logic       last_reg;
    logic       done_reg;
    logic       ovf_reg;
    logic       load;
    logic       is_last;

    assign load    = head_valid && (!valid_reg || out_ready);
    assign is_last = (idx_reg == (head.count - 2'd1));
    assign pop     = load && is_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (load)
            idx_next = is_last ? 2'd0 : (idx_reg + 2'd1);
    end

    // Token index within the head bundle and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (load)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tok_reg  <= head.tok[idx_reg];
            last_reg <= is_last;
            done_reg <= is_last && head.eol;
            ovf_reg  <= head.too_long;
        end
    end

    assign out_valid     = valid_reg;
    assign out_tok       = tok_reg;
    assign out_last      = last_reg;
    assign out_line_done = done_reg;
    assign out_too_long  = ovf_reg;

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (idx_reg < head.count))
        else $error("token index beyond head bundle");

    a_idx_rewind: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (idx_reg == 2'd0))
        else $error("token index not rewound after bundle");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && done_reg) |-> last_reg)
        else $error("line end flagged on a token that is not last");

endmodule

@@ rtl/core/expression_lexer_implicit_mul.sv @@
// Streaming lexer for arithmetic expressions with implicit multiplication.
// Characters enter on the s_ channel, one per transaction: s_tdata holds the
// ASCII byte and s_tlast marks the final character of a line. Tokens leave
// on the m_ channel, one per transaction, as kind, start position and
// length; m_tlast marks the last token caused by one character and
// m_tuser also carries the line-end and too-long flags.
// A character is accepted into the bundle queue, and its tokens are loaded
// from there into the output register. The front end takes one character
// per cycle while the queue is not full; the output register gives one token
// per cycle while the receiver is ready, so a character that causes one to
// three tokens holds the back end for each of them, and one with no token
// costs it nothing. A two-entry bundle queue between the halves absorbs bursts.
// Reset clears the scanner to the start of a line and empties the queue
// and the output register. When the receiver holds m_tready low the output
// token stays put, the queue fills with up to two more characters' bundles
// (only one when the bundle being unloaded still has tokens left) and then
// s_tready falls until the receiver takes a token again.
module expression_lexer_implicit_mul #(
    parameter int MAX_LINE = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    input  logic        s_tlast,   // end_of_line
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] token_start, [16:8] token_length, zero fill
    output logic [5:0]  m_tuser,   // [3:0] token_kind, [4] line_done, [5] too_long
    output logic        m_tlast    // last_of_run
);
    import elim_pkg::*;

    logic    q_full;
    logic    push;
    bundle_t push_data;
    logic    pop;
    logic    head_valid;
    bundle_t head;
    tok_t    out_tok;
    logic    out_line_done;
    logic    out_too_long;

    elim_front #(
        .MAX_LINE (MAX_LINE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_char   (s_tdata),
        .in_eol    (s_tlast),
        .q_full    (q_full),
        .in_ready  (s_tready),
        .push      (push),
        .push_data (push_data)
    );

    elim_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head)
    );

    elim_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head          (head),
        .pop           (pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_tok       (out_tok),
        .out_last      (m_tlast),
        .out_line_done (out_line_done),
        .out_too_long  (out_too_long)
    );

    // Pack the output token.
    assign m_tdata = {7'd0, out_tok.length, out_tok.start};
    assign m_tuser = {out_too_long, out_line_done, out_tok.kind};

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the streaming expression lexer with implicit multiply.
// Depends on elim_pkg for the token kind and scanner mode codes, and on the lexer top level.
module testbench;

    import elim_pkg::*;

    localparam int POS_LIMIT     = 256;
    localparam int RANDOM_ITEMS  = 420;
    localparam int LONG_RUN      = 258;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 20;

    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_NINE  = "9";
    localparam logic [7:0] CH_DOT   = ".";
    localparam logic [7:0] CH_UNDER = "_";
    localparam logic [7:0] CH_SPACE = " ";
    localparam logic [7:0] CH_SLASH = "/";
    localparam logic [7:0] CH_LOW_A = "a";
    localparam logic [7:0] CH_UP_A  = "A";

    // Scoreboard: tracks the lexer line state and queues the tokens each character should cause.
    class token_scoreboard;
        typedef struct {
            logic [3:0] kind;
            logic [7:0] start;
            logic [8:0] length;
            logic       last_run;
            logic       line_done;
            logic       too_long;
        } lex_token_t;

        lex_token_t  pending_tokens[$];
        logic [1:0]  scan_mode;
        logic [7:0]  run_start;
        logic [8:0]  run_length;
        logic [3:0]  prior_kind;
        logic [2:0]  sqrt_progress;
        logic [8:0]  column;
        logic        overflowed;
        int          mismatches;
        int          tokens_seen;
        int          sqrt_seen;
        int          implicit_seen;
        int          overflow_seen;
        int          saturated_seen;

        function new();
            reset_line();
        endfunction

        function void reset_line();
            scan_mode     = MODE_IDLE;
            run_start     = '0;
            run_length    = '0;
            prior_kind    = KIND_NONE;
            sqrt_progress = '0;
            column        = '0;
            overflowed    = 1'b0;
        endfunction

        function bit is_numeric(logic [7:0] c);
            return (c >= CH_ZERO && c <= CH_NINE) || c == CH_DOT;
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function bit is_word(logic [7:0] c);
            return is_letter(c) || c == CH_UNDER || (c >= CH_ZERO && c <= CH_NINE);
        endfunction

        function logic [3:0] operator_of(logic [7:0] c);
            case (c)
                "+":     return KIND_PLUS;
                "-":     return KIND_MINUS;
                "*":     return KIND_MUL;
                "/":     return KIND_DIV;
                "^":     return KIND_POW;
                "(":     return KIND_LPAREN;
                ")":     return KIND_RPAREN;
                ",":     return KIND_COMMA;
                default: return KIND_NONE;
            endcase
        endfunction

        function bit atom_before();
            return prior_kind == KIND_NUM || prior_kind == KIND_IDENT
                || prior_kind == KIND_RPAREN;
        endfunction

        function void push_token(logic [3:0] kind, logic [7:0] start, logic [8:0] length);
            lex_token_t t;
            t.kind      = kind;
            t.start     = start;
            t.length    = length;
            t.last_run  = 1'b0;
            t.line_done = 1'b0;
            t.too_long  = overflowed;
            pending_tokens.push_back(t);
            prior_kind = kind;
        endfunction

        // An open number or identifier is reported when its run ends.
        function void close_run();
            logic [3:0] kind;
            kind = KIND_NUM;
            if (scan_mode == MODE_IDENT)
                kind = (sqrt_progress == MATCH_FULL && run_length == 9'd4) ? KIND_SQRT
                                                                            : KIND_IDENT;
            scan_mode = MODE_IDLE;
            push_token(kind, run_start, run_length);
        endfunction

        // Predicts the tokens caused by one accepted character.
        function void take_char(logic [7:0] c, logic eol);
            logic [7:0] pos;
            logic [3:0] op;
            bit         grows;
            int         count_before;
            string      keyword;
            lex_token_t tail;
            keyword      = "sqrt";
            count_before = pending_tokens.size();

            // Positions saturate once the line passes its limit.
            if (column >= POS_LIMIT) begin
                overflowed = 1'b1;
                pos        = 8'(POS_LIMIT - 1);
            end
            else begin
                pos    = column[7:0];
                column = column + 9'd1;
            end

            grows = (scan_mode == MODE_NUM && is_numeric(c))
                 || (scan_mode == MODE_IDENT && is_word(c));

            if (grows) begin
                if (run_length < LEN_MAX)
                    run_length = run_length + 9'd1;
                if (scan_mode == MODE_IDENT) begin
                    if (sqrt_progress < MATCH_FULL && c == keyword[sqrt_progress])
                        sqrt_progress = sqrt_progress + 3'd1;
                    else
                        sqrt_progress = MATCH_FAIL;
                end
            end
            else begin
                if (scan_mode != MODE_IDLE)
                    close_run();
                if (is_numeric(c) || is_letter(c) || c == CH_UNDER) begin
                    if (atom_before())
                        push_token(KIND_MUL, pos, 9'd0);
                    scan_mode     = is_numeric(c) ? MODE_NUM : MODE_IDENT;
                    run_start     = pos;
                    run_length    = 9'd1;
                    sqrt_progress = (c == "s") ? 3'd1 : MATCH_FAIL;
                end
                else begin
                    op = operator_of(c);
                    if (op == KIND_LPAREN && atom_before())
                        push_token(KIND_MUL, pos, 9'd0);
                    if (op != KIND_NONE)
                        push_token(op, pos, 9'd1);
                end
            end

            if (eol && scan_mode != MODE_IDLE)
                close_run();

            // Flag the last token of this character, and of the line.
            if (pending_tokens.size() > count_before) begin
                tail           = pending_tokens.pop_back();
                tail.last_run  = 1'b1;
                tail.line_done = eol;
                pending_tokens.push_back(tail);
            end
            if (eol)
                reset_line();
        endfunction

        function int pending_count();
            return pending_tokens.size();
        endfunction

        function bit same(string field, int want, int got);
            if (want == got)
                return 1'b1;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            return 1'b0;
        endfunction

        // Compares one delivered token with the oldest prediction.
        function void check_token(logic [3:0] kind, logic [7:0] start, logic [8:0] length,
                                  logic last_run, logic line_done, logic too_long);
            lex_token_t want;
            bit         ok;
            if (pending_tokens.size() == 0) begin
                $display("%0t: unexpected token: expected none, actual kind %0d start %0d length %0d",
                         $time, kind, start, length);
                mismatches++;
                return;
            end
            want = pending_tokens.pop_front();
            ok = same("token_kind", want.kind, kind)
               & same("token_start", want.start, start)
               & same("token_length", want.length, length)
               & same("last_of_run", want.last_run, last_run)
               & same("line_done", want.line_done, line_done)
               & same("too_long", want.too_long, too_long);
            if (!ok) begin
                mismatches++;
                return;
            end
            tokens_seen++;
            if (kind == KIND_SQRT)
                sqrt_seen++;
            if (kind == KIND_MUL && length == 9'd0)
                implicit_seen++;
            if (too_long)
                overflow_seen++;
            if (length == LEN_MAX)
                saturated_seen++;
        endfunction
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;   // [7:0] token_start, [16:8] token_length, zero fill
    logic [5:0]  m_tuser;   // [3:0] token_kind, [4] line_done, [5] too_long
    logic        m_tlast;   // last_of_run

    token_scoreboard sb = new();
    bit         gaps_on     = 1'b1;
    int         hold_cycles = 0;
    int         cycles      = 0;
    int         chars_sent  = 0;
    int         lines_sent  = 0;
    logic [7:0] line_chars[$];

    expression_lexer_implicit_mul dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Clock with a 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one; none while gaps are off.
    function automatic int pick_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Token receiver: checks each transaction and stalls at random.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_token(m_tuser[3:0], m_tdata[7:0], m_tdata[16:8],
                           m_tlast, m_tuser[4], m_tuser[5]);
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready    <= 1'b0;
        end
        else if (gaps_on && $urandom_range(0, 4) == 0) begin
            hold_cycles <= pick_gap();
            m_tready    <= 1'b0;
        end
        else begin
            m_tready <= 1'b1;
        end
    end

    // Sends one character and waits for its transaction to complete.
    task automatic send_char(input logic [7:0] c, input logic eol);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eol;
        do @(posedge clk); while (!s_tready);
        sb.take_char(c, eol);
        chars_sent++;
    endtask

    task automatic send_text(input string s, input logic eol_at_end);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], eol_at_end && i == s.len() - 1);
    endtask

    task automatic send_line();
        for (int i = 0; i < line_chars.size(); i++)
            send_char(line_chars[i], i == line_chars.size() - 1);
        lines_sent++;
    endtask

    // Holds the sender until every predicted token has been delivered.
    task automatic drain_tokens();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending_count() != 0);
    endtask

    function automatic logic [7:0] rand_digit();
        return 8'(CH_ZERO + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(0, 1) == 0)
            return 8'(CH_LOW_A + $urandom_range(0, 25));
        return 8'(CH_UP_A + $urandom_range(0, 25));
    endfunction

    // Appends one piece of an expression line: a number, a name, an operator or filler.
    function automatic void add_fragment();
        int         r;
        int         n;
        string      w;
        logic [7:0] ch;
        r = $urandom_range(0, 99);
        if (r < 25) begin
            n = $urandom_range(1, 5);
            repeat (n) line_chars.push_back(($urandom_range(0, 4) == 0) ? CH_DOT : rand_digit());
        end
        else if (r < 45) begin
            if ($urandom_range(0, 4) == 0) begin
                case ($urandom_range(0, 5))
                    0, 1:    w = "sqrt";
                    2:       w = "sqr";
                    3:       w = "sqrt2";
                    4:       w = "s";
                    default: w = "Sqrt";
                endcase
                for (int i = 0; i < w.len(); i++)
                    line_chars.push_back(w[i]);
            end
            else begin
                line_chars.push_back(($urandom_range(0, 5) == 0) ? CH_UNDER : rand_letter());
                n = $urandom_range(0, 5);
                repeat (n) begin
                    case ($urandom_range(0, 5))
                        0:       ch = rand_digit();
                        1:       ch = CH_UNDER;
                        default: ch = rand_letter();
                    endcase
                    line_chars.push_back(ch);
                end
            end
        end
        else if (r < 75) begin
            w = "+-*/^(),((";
            line_chars.push_back(w[$urandom_range(0, w.len() - 1)]);
        end
        else if (r < 88) begin
            line_chars.push_back(CH_SPACE);
        end
        else if (r < 96) begin
            line_chars.push_back(8'($urandom_range(0, 255)));
        end
        else begin
            n = $urandom_range(10, 40);
            repeat (n) line_chars.push_back(rand_digit());
        end
    endfunction

    initial
    begin
        int random_start;
        int line_no;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed lines: every operator but +, the keyword, implicit multiplies,
        // skipped bytes, and a line end that causes no token.
        send_text("3.5x(a,b)^2", 1'b1);
        send_text("sqrt(1)(_y)-*", 1'b0);
        send_char(8'hFF, 1'b0);
        send_text("/ #", 1'b1);

        // Random lines, one of them past the position limit with a saturated number.
        random_start = chars_sent;
        line_no      = 0;
        while (chars_sent - random_start < RANDOM_ITEMS) begin
            gaps_on = !(line_no >= 6 && line_no < 10);
            if (line_no == 4)
                drain_tokens();
            line_chars.delete();
            if (line_no == 2) begin
                repeat (LONG_RUN) line_chars.push_back(rand_digit());
                line_chars.push_back("x");
                line_chars.push_back("(");
                line_chars.push_back("+");
                line_chars.push_back(")");
            end
            else begin
                repeat ($urandom_range(1, 12)) add_fragment();
            end
            send_line();
            line_no++;
        end
        gaps_on = 1'b1;

        drain_tokens();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d characters in %0d lines; %0d tokens matched, %0d mismatched.",
                 chars_sent, lines_sent + 2, sb.tokens_seen, sb.mismatches);
        $display("Seen: %0d sqrt, %0d implicit multiplies, %0d past the limit, %0d at full length.",
                 sb.sqrt_seen, sb.implicit_seen, sb.overflow_seen, sb.saturated_seen);
        if (sb.mismatches == 0 && sb.pending_count() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
